// ===== rtl/core/fud_pkg.sv =====
// Package with the shared types, byte codes and helpers of the form body decoder.
package fud_pkg;

  // Depth of the queue between the parser front and the result back end.
  localparam int unsigned QDepth = 4;

  // Byte codes that the parser reacts to.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Kind of a result word.
  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  // Escape progress.
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_FIRST = 2'd1,
    ESC_SECOND = 2'd2
  } esc_t;

  // One result word.
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       body_end;
    logic       run_last;
  } res_t;

  // All results caused by one input byte: one or two words.
  typedef struct packed {
    res_t first;
    res_t second;
    logic two;
  } entry_t;

  // Digit value of an escape character: 0-9, letters give 10-35, else 0.
  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41 + 8'd10;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd10;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end
    return v[5:0];
  endfunction

endpackage

// ===== rtl/core/form_urlencoded_decoder_top.sv =====
// Top level of the form body decoder: parser front, word queue and result back end.
// A word passes through the queue and the output register before it reaches the result ports.
// Throughput: one byte per cycle while the queue is not full; the output
// register drains one word per cycle while pop is held; a byte with two words takes two pops.
// A four-entry queue between parser and back end absorbs result-side stalls.
// Synchronous active-low reset clears parse state, queue and output valid flags.
module form_urlencoded_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_body_end,
  output logic       out_run_last,
  output logic       empty,
  input  logic       pop
);

  fud_pkg::entry_t wr_data, rd_data;
  logic            q_wr, q_rd, q_empty, accept;

  assign accept = push && !full;

  fud_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .q_wr      (q_wr),
    .q_data    (wr_data)
  );

  fud_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (wr_data),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (rd_data),
    .empty   (q_empty)
  );

  fud_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_data       (rd_data),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .out_body_end (out_body_end),
    .out_run_last (out_run_last)
  );

endmodule

// ===== rtl/core/fud_fifo.sv =====
// Short word queue that decouples the parser front from the result back end.
module fud_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  fud_pkg::entry_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output fud_pkg::entry_t rd_data,
  output logic            empty
);

  localparam int unsigned PtrW = $clog2(fud_pkg::QDepth);
  localparam int unsigned CntW = $clog2(fud_pkg::QDepth + 1);

  fud_pkg::entry_t mem_r [fud_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full    = (count_r == CntW'(fud_pkg::QDepth));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(fud_pkg::QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(fud_pkg::QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; the fill count guards reads.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/fud_front.sv =====
// Parser front: accepts body bytes, tracks pair state and forms result words.
module fud_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output logic            q_wr,
  output fud_pkg::entry_t q_data
);

  logic               in_value_r, in_value_nxt;
  fud_pkg::esc_t      esc_r, esc_nxt;
  logic [5:0]         high_digit_r, high_digit_nxt;
  logic               pair_open_r, pair_open_nxt;
  logic               halted_r, halted_nxt;

  // Classify the byte and form up to two result words.
  always_comb begin
    fud_pkg::res_t  res [2];
    logic [1:0]     n;
    fud_pkg::kind_t kind;
    logic [7:0]     escaped;

    in_value_nxt   = in_value_r;
    esc_nxt        = esc_r;
    high_digit_nxt = high_digit_r;
    pair_open_nxt  = pair_open_r;
    halted_nxt     = halted_r;
    n              = 2'd0;
    kind           = in_value_r ? fud_pkg::KIND_VALUE : fud_pkg::KIND_KEY;
    escaped        = 8'({high_digit_r[3:0], 4'b0000}) + {2'b00, fud_pkg::digit_value(data_byte)};
    for (int i = 0; i < 2; i++) begin
      res[i] = '{data: 8'd0, kind: fud_pkg::KIND_END, body_end: 1'b0, run_last: 1'b0};
    end

    if (!halted_r) begin
      priority if (data_byte == fud_pkg::CH_NUL) begin
        // A NUL closes an open pair and stops parsing.
        if (pair_open_r) begin
          res[0] = '{data: 8'd0, kind: fud_pkg::KIND_END, body_end: last_byte, run_last: 1'b0};
          n = 2'd1;
        end
        in_value_nxt   = 1'b0;
        esc_nxt        = fud_pkg::ESC_NONE;
        high_digit_nxt = '0;
        pair_open_nxt  = 1'b0;
        halted_nxt     = 1'b1;
      end else if (!pair_open_r && (data_byte == fud_pkg::CH_EQ ||
                                    data_byte == fud_pkg::CH_AMP)) begin
        // Empty key stops parsing.
        halted_nxt = 1'b1;
      end else if (data_byte == fud_pkg::CH_AMP) begin
        res[0] = '{data: 8'd0, kind: fud_pkg::KIND_END, body_end: last_byte, run_last: 1'b0};
        n = 2'd1;
        in_value_nxt   = 1'b0;
        esc_nxt        = fud_pkg::ESC_NONE;
        high_digit_nxt = '0;
        pair_open_nxt  = 1'b0;
      end else if (data_byte == fud_pkg::CH_EQ && !in_value_r) begin
        // The first equals sign ends the key and drops a pending escape.
        in_value_nxt   = 1'b1;
        esc_nxt        = fud_pkg::ESC_NONE;
        high_digit_nxt = '0;
      end else begin
        pair_open_nxt = 1'b1;
        priority if (esc_r == fud_pkg::ESC_FIRST) begin
          high_digit_nxt = fud_pkg::digit_value(data_byte);
          esc_nxt        = fud_pkg::ESC_SECOND;
        end else if (esc_r == fud_pkg::ESC_SECOND) begin
          res[0] = '{data: escaped, kind: kind, body_end: 1'b0, run_last: 1'b0};
          n = 2'd1;
          esc_nxt        = fud_pkg::ESC_NONE;
          high_digit_nxt = '0;
        end else if (data_byte == fud_pkg::CH_PLUS) begin
          res[0] = '{data: fud_pkg::CH_SPACE, kind: kind, body_end: 1'b0, run_last: 1'b0};
          n = 2'd1;
        end else if (data_byte == fud_pkg::CH_PCT) begin
          esc_nxt = fud_pkg::ESC_FIRST;
        end else begin
          res[0] = '{data: data_byte, kind: kind, body_end: 1'b0, run_last: 1'b0};
          n = 2'd1;
        end
      end
    end

    // The final byte closes a still open pair and returns to reset state.
    if (last_byte) begin
      if (!halted_nxt && pair_open_nxt) begin
        res[n[0]] = '{data: 8'd0, kind: fud_pkg::KIND_END, body_end: 1'b1, run_last: 1'b0};
        n = n + 2'd1;
      end
      in_value_nxt   = 1'b0;
      esc_nxt        = fud_pkg::ESC_NONE;
      high_digit_nxt = '0;
      pair_open_nxt  = 1'b0;
      halted_nxt     = 1'b0;
    end

    // Mark the last word caused by this byte.
    if (n == 2'd2) begin
      res[1].run_last = 1'b1;
    end else begin
      res[0].run_last = 1'b1;
    end

    q_data.first  = res[0];
    q_data.second = res[1];
    q_data.two    = (n == 2'd2);
    q_wr          = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_value_r   <= 1'b0;
      esc_r        <= fud_pkg::ESC_NONE;
      high_digit_r <= '0;
      pair_open_r  <= 1'b0;
      halted_r     <= 1'b0;
    end else if (accept) begin
      in_value_r   <= in_value_nxt;
      esc_r        <= esc_nxt;
      high_digit_r <= high_digit_nxt;
      pair_open_r  <= pair_open_nxt;
      halted_r     <= halted_nxt;
    end
  end

endmodule

// ===== rtl/core/fud_back.sv =====
// Result back end: splits queued entries into single words behind an output register.
module fud_back (
  input  logic            clk,
  input  logic            rst_n,
  input  fud_pkg::entry_t q_data,
  input  logic            q_empty,
  output logic            q_rd,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_body_end,
  output logic            out_run_last
);

  logic          out_valid_r, out_valid_nxt;
  fud_pkg::res_t out_res_r, out_res_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  fud_pkg::res_t pend_res_r, pend_res_nxt;
  logic          load;

  assign empty        = !out_valid_r;
  assign out_byte     = out_res_r.data;
  assign out_kind     = 2'(out_res_r.kind);
  assign out_body_end = out_res_r.body_end;
  assign out_run_last = out_res_r.run_last;

  // Refill the output register from the held second word or from the queue.
  always_comb begin
    load           = !out_valid_r || pop;
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    pend_valid_nxt = pend_valid_r;
    pend_res_nxt   = pend_res_r;
    q_rd           = 1'b0;
    if (load) begin
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = pend_res_r;
        pend_valid_nxt = 1'b0;
      end else if (!q_empty) begin
        q_rd           = 1'b1;
        out_valid_nxt  = 1'b1;
        out_res_nxt    = q_data.first;
        pend_valid_nxt = q_data.two;
        pend_res_nxt   = q_data.second;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    pend_res_r <= pend_res_nxt;
  end

endmodule

// ===== rtl/core/fud_checker.sv =====
// Port-level checks on the form body decoder and their binding to the top level.
module fud_checker (
  input logic       clk,
  input logic       rst_n,
  input logic [7:0] in_data_byte,
  input logic       in_last_byte,
  input logic       push,
  input logic       full,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind,
  input logic       out_body_end,
  input logic       out_run_last,
  input logic       empty,
  input logic       pop
);

  // Reset leaves no result word behind.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  // The end-of-body flag rides only on a pair-end word, which is also the last of its run.
  a_body_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_body_end) |-> (out_kind == 2'(fud_pkg::KIND_END) && out_run_last))
    else $error("body end flag on a word that is not a final pair end");

  // Pair-end words carry a zero byte, and no word has an unused kind code.
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_kind == 2'(fud_pkg::KIND_END) && out_byte == 8'd0) ||
                out_kind == 2'(fud_pkg::KIND_KEY) || out_kind == 2'(fud_pkg::KIND_VALUE)))
    else $error("bad pair-end word or kind code");

  // A stalled result word holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_kind) &&
                          $stable(out_body_end) && $stable(out_run_last)))
    else $error("stalled result word changed");

endmodule

bind form_urlencoded_decoder_top fud_checker u_fud_checker (.*);
